// ===== sv/assert_macros.svh =====
// Assertion macros for the peer table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define PT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define PT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== sv/ptfc_pkg.sv =====
// Shared types, codes and constants of the peer table.
package ptfc_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BYTES_DEF   = 32;

    localparam int OP_W     = 4;
    localparam int IDENT_W  = 32;
    localparam int ADDR_W   = 32;
    localparam int FAULT_W  = 8;
    localparam int COUNT_W  = 5;
    localparam int THR_W    = 8;
    localparam int KEY_IN_W = 256;

    localparam logic [THR_W-1:0]   THR_RESET = 8'd15;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 8'hFF;

    localparam logic [OP_W-1:0] OP_ADD         = 4'd0;
    localparam logic [OP_W-1:0] OP_REMOVE      = 4'd1;
    localparam logic [OP_W-1:0] OP_MARK        = 4'd2;
    localparam logic [OP_W-1:0] OP_RESET       = 4'd3;
    localparam logic [OP_W-1:0] OP_INFO        = 4'd4;
    localparam logic [OP_W-1:0] OP_ADDR_BY_ID  = 4'd5;
    localparam logic [OP_W-1:0] OP_ADDR_BY_KEY = 4'd6;
    localparam logic [OP_W-1:0] OP_ID_BY_KEY   = 4'd7;
    localparam logic [OP_W-1:0] OP_COUNTS      = 4'd8;

    // one table entry, key carried separately since its width is a parameter
    typedef struct packed {
        logic               valid;
        logic [IDENT_W-1:0] ident;
        logic [ADDR_W-1:0]  addr;
        logic [FAULT_W-1:0] faults;
        logic               flag;
    } t_entry;

    // operation held for the whole scan
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDENT_W-1:0] ident;
        logic [ADDR_W-1:0]  addr;
        logic [THR_W-1:0]   thr;
    } t_req;

    // scan token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               dup;
        logic               free_seen;
        logic               added;
        logic [IDENT_W-1:0] f_ident;
        logic [ADDR_W-1:0]  f_addr;
        logic [FAULT_W-1:0] f_faults;
        logic               f_flag;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] active;
    } t_scan;

    function automatic logic uses_key(input logic [OP_W-1:0] op);
        return (op == OP_ADDR_BY_KEY) || (op == OP_ID_BY_KEY);
    endfunction

endpackage

// ===== sv/ptfc_cell.sv =====
// One table cell: holds one entry and acts on the scan token as it passes.
module ptfc_cell #(
    parameter int KEY_BITS = 8 * ptfc_pkg::KEY_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptfc_pkg::t_req       i_req,
    input  logic [KEY_BITS-1:0]  i_req_key,
    input  ptfc_pkg::t_scan      i_scan,
    output ptfc_pkg::t_scan      o_scan,
    input  ptfc_pkg::t_entry     i_nb_entry,
    input  logic [KEY_BITS-1:0]  i_nb_key,
    output ptfc_pkg::t_entry     o_entry,
    output logic [KEY_BITS-1:0]  o_key
);

    ptfc_pkg::t_entry r_entry, n_entry;
    logic [KEY_BITS-1:0] r_key, n_key;
    ptfc_pkg::t_scan r_scan, n_scan;

    logic id_match, key_match, hit_here;
    logic [ptfc_pkg::FAULT_W-1:0] fault_inc;

    assign id_match  = r_entry.valid && (r_entry.ident == i_req.ident);
    assign key_match = r_entry.valid && (r_key == i_req_key);
    assign hit_here  = (ptfc_pkg::uses_key(i_req.op) ? key_match : id_match) && !i_scan.hit;
    assign fault_inc = (r_entry.faults == ptfc_pkg::FAULT_MAX) ? r_entry.faults
                                                               : r_entry.faults + 8'd1;

    always_comb begin
        n_entry = r_entry;
        n_key   = r_key;
        n_scan  = i_scan;
        if (i_scan.valid) begin
            if (hit_here) begin
                n_scan.hit = 1'b1;
            end
            unique case (i_req.op)
                ptfc_pkg::OP_ADD: begin
                    if (id_match || key_match) begin
                        n_scan.dup = 1'b1;
                    end
                    // first free cell sits right after the used ones
                    if (!r_entry.valid && !i_scan.free_seen) begin
                        n_scan.free_seen = 1'b1;
                        if (!i_scan.dup) begin
                            n_entry.valid  = 1'b1;
                            n_entry.ident  = i_req.ident;
                            n_entry.addr   = i_req.addr;
                            n_entry.faults = '0;
                            n_entry.flag   = 1'b0;
                            n_key          = i_req_key;
                            n_scan.added   = 1'b1;
                        end
                    end
                end
                ptfc_pkg::OP_REMOVE: begin
                    // compaction: hit cell and all after it pull from the right
                    if (hit_here || i_scan.hit) begin
                        n_entry = i_nb_entry;
                        n_key   = i_nb_key;
                    end
                end
                ptfc_pkg::OP_MARK: begin
                    if (hit_here) begin
                        n_entry.faults = fault_inc;
                        if (fault_inc >= i_req.thr) begin
                            n_entry.flag = 1'b1;
                        end
                    end
                end
                ptfc_pkg::OP_RESET: begin
                    if (hit_here) begin
                        n_entry.faults = '0;
                        n_entry.flag   = 1'b0;
                    end
                end
                ptfc_pkg::OP_INFO: begin
                    if (hit_here) begin
                        n_scan.f_ident  = r_entry.ident;
                        n_scan.f_addr   = r_entry.addr;
                        n_scan.f_faults = r_entry.faults;
                        n_scan.f_flag   = r_entry.flag;
                    end
                end
                ptfc_pkg::OP_ADDR_BY_ID, ptfc_pkg::OP_ADDR_BY_KEY: begin
                    if (hit_here) begin
                        n_scan.f_addr = r_entry.addr;
                    end
                end
                ptfc_pkg::OP_ID_BY_KEY: begin
                    if (hit_here) begin
                        n_scan.f_ident = r_entry.ident;
                    end
                end
                default: begin
                end
            endcase
            n_scan.total  = i_scan.total + {4'd0, n_entry.valid};
            n_scan.active = i_scan.active + {4'd0, n_entry.valid && !n_entry.flag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_scan.valid  <= 1'b0;
        end else begin
            r_entry <= n_entry;
            r_scan  <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_scan  = r_scan;
    assign o_entry = r_entry;
    assign o_key   = r_key;

endmodule

// ===== sv/peer_table_with_fault_counters_core.sv =====
// Top level of the peer table with fault counters: stream ports and scan control.
//
// Usage
//   Input stream (s_axis_*): one transaction per operation; tuser carries the
//   opcode, tdata the id, the 256-bit key and the IPv4 address.
//   Output stream (m_axis_*): exactly one result transaction per operation,
//   in order: ok, found id/address/faults/flag, total and active peer counts.
//   Config: i_cfg_we writes i_cfg_wdata into the fault threshold.
// Timing
//   The table is a row of TABLE_DEPTH cells, one entry each. A scan token walks
//   the row one cell per cycle, every cell acting on its own entry and passing
//   match, found data and running counts to its neighbor. Remove compacts by
//   having the hit cell and those after it copy their right neighbor.
//   The result passes from the start register through the cells and the parked
//   result register into the output register; one operation is in flight at a
//   time, so a new transaction is taken only once the last result has moved on.
// Reset: synchronous, active low; table empty, threshold 15, both streams idle.
// Stalls: the result waits in the output register while m_axis_tready is low;
//   the next operation is still accepted and scanned, its result parked until
//   the output register frees.
module peer_table_with_fault_counters_core #(
    parameter int TABLE_DEPTH = ptfc_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = ptfc_pkg::KEY_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: peer_ident[31:0], key_word0..3 (256 bits), net_addr[31:0]
    input  logic [319:0] s_axis_tdata,
    // tuser, low bit up: opcode[3:0]
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: ok, found_ident[31:0], found_addr[31:0], found_faults[7:0],
    // found_delinquent, total_peers[4:0], active_peers[4:0], 4 zero pad bits
    output logic [87:0]  m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int KEY_BITS = 8 * KEY_BYTES;

    logic [ptfc_pkg::THR_W-1:0] r_thr;
    logic                       r_busy;
    ptfc_pkg::t_req             r_req;
    logic [KEY_BITS-1:0]        r_key;
    ptfc_pkg::t_scan            r_start, n_start;
    ptfc_pkg::t_scan            r_done;
    logic                       r_done_valid;
    logic                       r_m_valid;
    logic [87:0]                r_m_data;

    // scan tokens: index 0 is the injected token, index k+1 is cell k's output
    ptfc_pkg::t_scan  w_scan [TABLE_DEPTH+1];
    // entries: index k is cell k, the last slot is an empty entry past the end
    ptfc_pkg::t_entry w_ent  [TABLE_DEPTH+1];
    logic [KEY_BITS-1:0] w_key [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] w_tok;

    logic accept, move, res_ok;

    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && !r_busy;
    assign move          = r_done_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ptfc_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // operation register, held until the scan is done
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op    <= s_axis_tuser;
            r_req.ident <= s_axis_tdata[31:0];
            r_req.addr  <= s_axis_tdata[288 +: 32];
            r_req.thr   <= r_thr;
            r_key       <= s_axis_tdata[32 +: KEY_BITS];
        end
    end

    always_comb begin
        n_start       = '0;
        n_start.valid = accept;
    end

    assign w_scan[0]           = r_start;
    assign w_ent[TABLE_DEPTH]  = '0;
    assign w_key[TABLE_DEPTH]  = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        ptfc_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (r_req),
            .i_req_key  (r_key),
            .i_scan     (w_scan[k]),
            .o_scan     (w_scan[k+1]),
            .i_nb_entry (w_ent[k+1]),
            .i_nb_key   (w_key[k+1]),
            .o_entry    (w_ent[k]),
            .o_key      (w_key[k])
        );
    end

    for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_tok
        assign w_tok[k] = w_scan[k].valid;
    end

    // ok per opcode: add succeeds on write, counts always, remove, mark, reset and lookups on hit, unused codes never
    always_comb begin
        priority if (r_req.op == ptfc_pkg::OP_ADD) begin
            res_ok = r_done.added;
        end else if (r_req.op == ptfc_pkg::OP_COUNTS) begin
            res_ok = 1'b1;
        end else if (r_req.op == ptfc_pkg::OP_REMOVE || r_req.op == ptfc_pkg::OP_MARK ||
                     r_req.op == ptfc_pkg::OP_RESET || r_req.op == ptfc_pkg::OP_INFO ||
                     r_req.op == ptfc_pkg::OP_ADDR_BY_ID ||
                     r_req.op == ptfc_pkg::OP_ADDR_BY_KEY ||
                     r_req.op == ptfc_pkg::OP_ID_BY_KEY) begin
            res_ok = r_done.hit;
        end else begin
            res_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_start.valid <= 1'b0;
            r_done_valid  <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            r_start <= n_start;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            // token leaving the last cell is parked until the output frees
            if (w_scan[TABLE_DEPTH].valid) begin
                r_done_valid <= 1'b1;
                r_done       <= w_scan[TABLE_DEPTH];
            end else if (move) begin
                r_done_valid <= 1'b0;
            end
            if (move) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_m_data <= {4'd0, r_done.active, r_done.total, r_done.f_flag,
                         r_done.f_faults, r_done.f_addr, r_done.f_ident, res_ok};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // at most one token anywhere in the row or parked
    `PT_ASSERT(a_single_token, $onehot0({r_done_valid, w_tok}), "more than one scan token")
    // a token in the row means an operation is in flight
    `PT_ASSERT(a_token_busy, (|w_tok) |-> r_busy, "scan token without busy")
    // a fresh result always comes from the parked scan result
    `PT_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(r_done_valid),
               "output valid without finished scan")

endmodule

// ===== tb/tb_peer_table_with_fault_counters_core.sv =====
// Testbench for the peer table core: directed and random ops checked against a predictor or by hand.
module tb_peer_table_with_fault_counters_core;
    import ptfc_pkg::*;

    // ------------------------------------------------------------------
    // Sizes, codes and run limits
    // ------------------------------------------------------------------
    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int KEY_BITS   = KEY_BYTES_DEF * 8;
    localparam int POOL_SIZE  = 24;
    // Idle time after the last result, before the final report.
    localparam int DRAIN      = 2 * DEPTH + 8;
    localparam int LONG_HOLD  = 300;
    // Watchdog limit on the whole run, including the long hold.
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTS = 50;

    // Top of the unused opcode range (everything above OP_COUNTS is a no-op).
    localparam logic [OP_W-1:0] OP_LAST_CODE = 4'hF;

    // Only the low KEY_BYTES bytes of a key are stored and compared.
    localparam logic [KEY_IN_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_IN_W) ? {KEY_IN_W{1'b1}} : ((256'd1 << KEY_BITS) - 256'd1);

    // Key selectors for the directed table.
    typedef enum int {KSEL_ZERO, KSEL_ONES, KSEL_SPARE} t_key_sel;

    // Result transaction, laid out exactly as m_axis_tdata[83:0] (ok at bit 0).
    typedef struct packed {
        logic [COUNT_W-1:0] active;
        logic [COUNT_W-1:0] total;
        logic               flag;
        logic [FAULT_W-1:0] faults;
        logic [ADDR_W-1:0]  addr;
        logic [IDENT_W-1:0] ident;
        logic               ok;
    } t_peer_result;

    // One row of the directed stimulus table.
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [IDENT_W-1:0] ident;
        t_key_sel           ksel;
        logic [ADDR_W-1:0]  addr;
        bit                 typed;   // want holds a hand-written expectation
        t_peer_result       want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time 0
    // ------------------------------------------------------------------
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [7:0]   i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata, low bit up: peer_ident[31:0], key_word0..3 (256 bits), net_addr[31:0]
    logic [319:0] s_axis_tdata  = '0;
    // tuser, low bit up: opcode[3:0]
    logic [3:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata, low bit up: ok, found_ident[31:0], found_addr[31:0], found_faults[7:0],
    // found_delinquent, total_peers[4:0], active_peers[4:0], 4 zero pad bits
    logic [87:0]  m_axis_tdata;

    peer_table_with_fault_counters_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the compacted table and threshold
    // ------------------------------------------------------------------
    logic [IDENT_W-1:0]  pt_ident  [DEPTH];
    logic [KEY_IN_W-1:0] pt_key    [DEPTH];
    logic [ADDR_W-1:0]   pt_addr   [DEPTH];
    logic [FAULT_W-1:0]  pt_faults [DEPTH];
    logic                pt_flag   [DEPTH];
    int                  pt_total;
    logic [THR_W-1:0]    pt_thr;

    // Stimulus pools: small so that ids and keys collide often.
    logic [IDENT_W-1:0]  id_pool  [POOL_SIZE];
    logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];

    t_peer_result pending_results[$];   // expected results, oldest first
    t_dir_row     dir_rows[$];

    int unsigned cycle_count     = 0;
    int          mismatch_count  = 0;
    int          ops_sent        = 0;
    int          results_checked = 0;
    int          full_refusals   = 0;
    int          saturated_marks = 0;
    int          thr_writes      = 0;
    int          hold_cycles     = 0;   // set by the sender, consumed by the receiver
    bit          no_idle         = 1'b0;

    // ------------------------------------------------------------------
    // Predictor: applies one operation to the table copy, returns its result
    // ------------------------------------------------------------------
    function automatic t_peer_result apply_peer_op(input logic [OP_W-1:0]     op,
                                                   input logic [IDENT_W-1:0]  id,
                                                   input logic [KEY_IN_W-1:0] key_in,
                                                   input logic [ADDR_W-1:0]   addr);
        t_peer_result r;
        logic [KEY_IN_W-1:0] key;
        int id_hit;
        int key_hit;
        int n_act;
        r       = '0;
        key     = key_in & KEY_MASK;
        id_hit  = -1;
        key_hit = -1;
        // first match wins for both searches
        for (int i = 0; i < pt_total; i++) begin
            if (id_hit < 0 && pt_ident[i] == id) id_hit = i;
            if (key_hit < 0 && pt_key[i] == key) key_hit = i;
        end
        case (op)
            OP_ADD: begin
                if (pt_total == DEPTH) full_refusals++;
                if (pt_total < DEPTH && id_hit < 0 && key_hit < 0) begin
                    pt_ident[pt_total]  = id;
                    pt_key[pt_total]    = key;
                    pt_addr[pt_total]   = addr;
                    pt_faults[pt_total] = '0;
                    pt_flag[pt_total]   = 1'b0;
                    pt_total++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (id_hit >= 0) begin
                    // compaction: later entries slide down by one
                    for (int i = id_hit; i < pt_total - 1; i++) begin
                        pt_ident[i]  = pt_ident[i+1];
                        pt_key[i]    = pt_key[i+1];
                        pt_addr[i]   = pt_addr[i+1];
                        pt_faults[i] = pt_faults[i+1];
                        pt_flag[i]   = pt_flag[i+1];
                    end
                    pt_total--;
                    r.ok = 1'b1;
                end
            end
            OP_MARK: begin
                if (id_hit >= 0) begin
                    if (pt_faults[id_hit] != FAULT_MAX) pt_faults[id_hit] = pt_faults[id_hit] + 1'b1;
                    else saturated_marks++;
                    // sticky; a zero threshold flags on every mark
                    if (pt_faults[id_hit] >= pt_thr) pt_flag[id_hit] = 1'b1;
                    r.ok = 1'b1;
                end
            end
            OP_RESET: begin
                if (id_hit >= 0) begin
                    pt_faults[id_hit] = '0;
                    pt_flag[id_hit]   = 1'b0;
                    r.ok = 1'b1;
                end
            end
            OP_INFO: begin
                if (id_hit >= 0) begin
                    r.ok     = 1'b1;
                    r.ident  = pt_ident[id_hit];
                    r.addr   = pt_addr[id_hit];
                    r.faults = pt_faults[id_hit];
                    r.flag   = pt_flag[id_hit];
                end
            end
            OP_ADDR_BY_ID: begin
                if (id_hit >= 0) begin
                    r.ok   = 1'b1;
                    r.addr = pt_addr[id_hit];
                end
            end
            OP_ADDR_BY_KEY: begin
                if (key_hit >= 0) begin
                    r.ok   = 1'b1;
                    r.addr = pt_addr[key_hit];
                end
            end
            OP_ID_BY_KEY: begin
                if (key_hit >= 0) begin
                    r.ok    = 1'b1;
                    r.ident = pt_ident[key_hit];
                end
            end
            OP_COUNTS: r.ok = 1'b1;
            default: ;  // unused opcodes change nothing
        endcase
        n_act = 0;
        for (int i = 0; i < pt_total; i++)
            if (!pt_flag[i]) n_act++;
        r.total  = COUNT_W'(pt_total);
        r.active = COUNT_W'(n_act);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_checked, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_peer_result got);
        t_peer_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("no expectation waiting", got.ok, 32'h0);
        end else begin
            want = pending_results.pop_front();
            if (got.ok     !== want.ok)     report_mismatch("ok", got.ok, want.ok);
            if (got.ident  !== want.ident)  report_mismatch("found_ident", got.ident, want.ident);
            if (got.addr   !== want.addr)   report_mismatch("found_addr", got.addr, want.addr);
            if (got.faults !== want.faults) report_mismatch("found_faults", got.faults, want.faults);
            if (got.flag   !== want.flag)   report_mismatch("found_delinquent", got.flag, want.flag);
            if (got.total  !== want.total)  report_mismatch("total_peers", got.total, want.total);
            if (got.active !== want.active) report_mismatch("active_peers", got.active, want.active);
        end
        results_checked++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [KEY_IN_W-1:0] random_key();
        logic [KEY_IN_W-1:0] k;
        for (int w = 0; w < KEY_IN_W / 32; w++) k[w*32 +: 32] = $urandom;
        return k;
    endfunction

    // Mostly pool keys, some one-bit near misses, some fresh keys.
    function automatic logic [KEY_IN_W-1:0] pick_key();
        logic [KEY_IN_W-1:0] k;
        int r;
        r = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r >= 85) k = random_key();
        else if (r >= 70) k[$urandom_range(0, KEY_IN_W - 1)] ^= 1'b1;
        return k;
    endfunction

    function automatic logic [IDENT_W-1:0] pick_ident();
        if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [31:0] id,
                                    input t_key_sel ksel, input logic [31:0] addr,
                                    input bit typed, input logic ok, input logic [31:0] fid,
                                    input logic [31:0] faddr, input logic [7:0] ffaults,
                                    input logic fflag, input logic [4:0] tot,
                                    input logic [4:0] act);
        t_dir_row row;
        row.op    = op;
        row.ident = id;
        row.ksel  = ksel;
        row.addr  = addr;
        row.typed = typed;
        row.want  = '{active: act, total: tot, flag: fflag, faults: ffaults,
                      addr: faddr, ident: fid, ok: ok};
        dir_rows.push_back(row);
    endfunction

    // Row checked only against the predictor.
    function automatic void add_free_row(input logic [OP_W-1:0] op, input logic [31:0] id,
                                         input t_key_sel ksel, input logic [31:0] addr);
        add_row(op, id, ksel, addr, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0, '0);
    endfunction

    // Offer one operation; returns once the input transaction is accepted.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [IDENT_W-1:0] id,
                           input logic [KEY_IN_W-1:0] key, input logic [ADDR_W-1:0] addr,
                           input bit typed, input t_peer_result typed_want);
        int gap;
        t_peer_result pred;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {addr, key, id};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // accepted at this edge: predict in acceptance order
        pred = apply_peer_op(op, id, key, addr);
        pending_results.push_back(typed ? typed_want : pred);
        ops_sent++;
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Threshold write, only ever done with the block idle.
    task automatic set_threshold(input logic [THR_W-1:0] thr);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pt_thr = thr;
        thr_writes++;
    endtask

    // Random mix; add_w and rem_w steer the table occupancy (percent).
    task automatic run_mixed(input int n, input int add_w, input int rem_w);
        int r;
        int j;
        logic [OP_W-1:0]     op;
        logic [IDENT_W-1:0]  id;
        logic [KEY_IN_W-1:0] key;
        for (int k = 0; k < n; k++) begin
            r   = $urandom_range(0, 99);
            id  = pick_ident();
            key = pick_key();
            if (r < add_w) begin
                // pair id j with key j most of the time so key lookups line up
                op = OP_ADD;
                j  = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 9) != 0) id = id_pool[j];
                if ($urandom_range(0, 9) < 7) key = key_pool[j];
            end else if (r < add_w + rem_w) begin
                op = OP_REMOVE;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35)      op = OP_MARK;
                else if (r < 43) op = OP_RESET;
                else if (r < 57) op = OP_INFO;
                else if (r < 67) op = OP_ADDR_BY_ID;
                else if (r < 77) op = OP_ADDR_BY_KEY;
                else if (r < 87) op = OP_ID_BY_KEY;
                else if (r < 93) op = OP_COUNTS;
                else             op = OP_W'($urandom_range(OP_COUNTS + 1, OP_LAST_CODE));
            end
            send_op(op, id, key, $urandom, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Cycle counter and watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random ready gaps, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (hold_cycles > 0) begin
                // long hold lets the block park a result and stall its input
                stall       = stall + hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            // handshake at this edge; outputs still hold their pre-edge values
            check_result(t_peer_result'(m_axis_tdata[83:0]));
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [KEY_IN_W-1:0] key;
        t_dir_row row;

        for (int p = 0; p < POOL_SIZE; p++) begin
            id_pool[p]  = $urandom;
            key_pool[p] = random_key();
        end
        // extremes live in the pool too
        id_pool[0]  = '0;
        id_pool[1]  = '1;
        key_pool[0] = '0;
        key_pool[1] = '1;

        pt_total = 0;
        pt_thr   = THR_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run at the reset threshold of 15.
        //      op              id            key         addr         typ ok ident  addr   flt fl tot act
        add_row(OP_COUNTS,      32'h0,        KSEL_ZERO,  32'h0,       1,  1, 32'h0, 32'h0, 0,  0, 0,  0);
        add_row(OP_INFO,        32'h0,        KSEL_ZERO,  32'h0,       1,  0, 32'h0, 32'h0, 0,  0, 0,  0);
        add_row(OP_LAST_CODE,   32'hFFFFFFFF, KSEL_ONES,  32'hFFFFFFFF, 1, 0, 32'h0, 32'h0, 0,  0, 0,  0);
        add_row(OP_ADD,         32'h0,        KSEL_ZERO,  32'h0,       1,  1, 32'h0, 32'h0, 0,  0, 1,  1);
        add_row(OP_ADD,         32'hFFFFFFFF, KSEL_ONES,  32'hFFFFFFFF, 1, 1, 32'h0, 32'h0, 0,  0, 2,  2);
        // duplicate id, then duplicate key: both refused
        add_row(OP_ADD,         32'h0,        KSEL_SPARE, 32'h7B,      1,  0, 32'h0, 32'h0, 0,  0, 2,  2);
        add_row(OP_ADD,         32'h5,        KSEL_ONES,  32'h7B,      1,  0, 32'h0, 32'h0, 0,  0, 2,  2);
        add_row(OP_INFO,        32'hFFFFFFFF, KSEL_ZERO,  32'h0,       1,  1, 32'hFFFFFFFF,
                32'hFFFFFFFF, 0, 0, 2, 2);
        add_free_row(OP_ADDR_BY_ID,  32'h0, KSEL_ONES,  32'h0);
        add_row(OP_ADDR_BY_KEY, 32'h7,        KSEL_ONES,  32'h0,       1,  1, 32'h0, 32'hFFFFFFFF,
                0, 0, 2, 2);
        add_free_row(OP_ID_BY_KEY,   32'h7, KSEL_ZERO,  32'h0);
        add_row(OP_ID_BY_KEY,   32'h0,        KSEL_SPARE, 32'h0,       1,  0, 32'h0, 32'h0, 0,  0, 2,  2);
        add_free_row(OP_ADDR_BY_KEY, 32'h0, KSEL_SPARE, 32'h0);
        add_row(OP_MARK,        32'h0,        KSEL_ZERO,  32'h0,       1,  1, 32'h0, 32'h0, 0,  0, 2,  2);
        add_free_row(OP_INFO,        32'h0, KSEL_ZERO,  32'h0);
        add_free_row(OP_RESET,       32'h0, KSEL_ZERO,  32'h0);
        // operations on an id that is not in the table
        add_row(OP_RESET,       32'h7,        KSEL_ZERO,  32'h0,       1,  0, 32'h0, 32'h0, 0,  0, 2,  2);
        add_row(OP_MARK,        32'h7,        KSEL_ZERO,  32'h0,       1,  0, 32'h0, 32'h0, 0,  0, 2,  2);
        add_free_row(OP_ADDR_BY_ID,  32'h7, KSEL_ZERO,  32'h0);
        // removing the first entry shifts the second one down
        add_row(OP_REMOVE,      32'h0,        KSEL_ZERO,  32'h0,       1,  1, 32'h0, 32'h0, 0,  0, 1,  1);
        add_free_row(OP_INFO,        32'hFFFFFFFF, KSEL_ZERO, 32'h0);
        add_row(OP_REMOVE,      32'h7,        KSEL_ZERO,  32'h0,       1,  0, 32'h0, 32'h0, 0,  0, 1,  1);
        add_free_row(OP_W'(OP_COUNTS + 1), 32'h0, KSEL_SPARE, 32'h0);
        add_row(OP_REMOVE,      32'hFFFFFFFF, KSEL_ZERO,  32'h0,       1,  1, 32'h0, 32'h0, 0,  0, 0,  0);
        add_free_row(OP_COUNTS,      32'h0, KSEL_ZERO,  32'h0);

        foreach (dir_rows[d]) begin
            row = dir_rows[d];
            case (row.ksel)
                KSEL_ZERO: key = '0;
                KSEL_ONES: key = '1;
                default:   key = key_pool[2];
            endcase
            send_op(row.op, row.ident, key, row.addr, row.typed, row.want);
        end

        // Highest threshold: fill past full, then drive one peer to saturation.
        set_threshold(8'd255);
        for (int p = 0; p < 20; p++)
            send_op(OP_ADD, id_pool[p], key_pool[p], $urandom, 1'b0, '0);
        for (int m = 0; m < 260; m++) begin
            send_op(OP_MARK, id_pool[2], random_key(), $urandom, 1'b0, '0);
            if (m % 64 == 63) send_op(OP_INFO, id_pool[2], random_key(), $urandom, 1'b0, '0);
        end
        send_op(OP_INFO, id_pool[2], random_key(), $urandom, 1'b0, '0);

        // Lowest nonzero threshold: first mark flags.
        set_threshold(8'd1);
        run_mixed(180, 30, 15);

        // Zero threshold: every mark flags.
        set_threshold(8'd0);
        run_mixed(150, 20, 20);

        // Back-to-back traffic with a long result hold-off at the start.
        set_threshold(8'd3);
        no_idle     = 1'b1;
        hold_cycles = LONG_HOLD;
        run_mixed(150, 25, 10);
        no_idle     = 1'b0;

        // Random threshold, removal-heavy so the table drains.
        set_threshold(THR_W'($urandom_range(1, 254)));
        run_mixed(220, 15, 25);

        // Reset value again, add-heavy so the table stays near full.
        set_threshold(THR_RESET);
        run_mixed(290, 35, 10);

        drain_results();
        repeat (DRAIN) @(posedge i_clk);

        $display("run covered %0d operations over %0d threshold settings, %0d results checked",
                 ops_sent, thr_writes + 1, results_checked);
        $display("full-table add refusals %0d, marks at saturation %0d, mismatches %0d",
                 full_refusals, saturated_marks, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== peer_table_with_fault_counters_core.f =====
+incdir+sv
sv/ptfc_pkg.sv
sv/ptfc_cell.sv
sv/peer_table_with_fault_counters_core.sv
tb/tb_peer_table_with_fault_counters_core.sv
